// ===== design/adfc_pkg.sv =====
package adfc_pkg;

	localparam logic [15:0] MAX_FRAME_BYTES = 16'hFFFF;

	localparam logic [7:0] DELIM   = 8'h7E;
	localparam logic [7:0] ESC     = 8'h7D;
	localparam logic [7:0] ESC_XOR = 8'h20;
	localparam logic [7:0] SUM_OK  = 8'hFF;

	localparam logic [6:0] MIN_PAYLOAD_START = 7'd4;
	localparam logic [15:0] HEADER_BYTES = 16'd4;

	localparam logic [7:0] RX_API_ID_RESET     = 8'd144;
	localparam logic [6:0] PAYLOAD_START_RESET = 7'd15;

	localparam logic REG_RX_API_ID     = 1'b0;
	localparam logic REG_PAYLOAD_START = 1'b1;

	localparam logic [2:0] VERDICT_OK        = 3'd0;
	localparam logic [2:0] VERDICT_BAD_DELIM = 3'd1;
	localparam logic [2:0] VERDICT_BAD_LEN   = 3'd2;
	localparam logic [2:0] VERDICT_BAD_SUM   = 3'd3;
	localparam logic [2:0] VERDICT_OTHER_API = 3'd4;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       frame_end;
		logic [2:0] verdict;
	} res_t;

	typedef struct packed {
		logic valid;
		res_t res;
	} push_t;

endpackage

// ===== design/adfc_front.sv =====
module adfc_front
	import adfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_accept,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output push_t      push
);

	logic [7:0]  rx_api_id_q;
	logic [6:0]  payload_start_q;

	logic [15:0] byte_index_q, byte_index_n;
	logic        esc_q, esc_n;
	logic [15:0] length_q, length_n;
	logic [7:0]  sum_q, sum_n;
	logic [7:0]  type_q, type_n;
	logic        delim_ok_q, delim_ok_n;
	logic [7:0]  held_q, held_n;
	logic        held_valid_q, held_valid_n;

	logic        have;
	logic        trailing;
	logic [7:0]  ub;
	logic        out_valid;
	logic [6:0]  start;
	logic [2:0]  verdict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_api_id_q     <= RX_API_ID_RESET;
			payload_start_q <= PAYLOAD_START_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RX_API_ID:     rx_api_id_q <= cfg_data;
				REG_PAYLOAD_START: payload_start_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign start = (payload_start_q < MIN_PAYLOAD_START) ? MIN_PAYLOAD_START : payload_start_q;

	always_comb begin
		have         = 1'b0;
		trailing     = 1'b0;
		ub           = in_byte;
		out_valid    = 1'b0;
		byte_index_n = byte_index_q;
		esc_n        = esc_q;
		length_n     = length_q;
		sum_n        = sum_q;
		type_n       = type_q;
		delim_ok_n   = delim_ok_q;
		held_n       = held_q;
		held_valid_n = held_valid_q;

		if (byte_index_q == '0) begin
			delim_ok_n = (in_byte == DELIM);
			have       = 1'b1;
		end else if (esc_q) begin
			ub    = in_byte ^ ESC_XOR;
			esc_n = 1'b0;
			have  = 1'b1;
		end else if (in_byte == ESC) begin
			trailing = in_last;
			esc_n    = !in_last;
		end else begin
			have = 1'b1;
		end

		if (have) begin
			if (byte_index_q == 16'd1) length_n[15:8] = ub;
			if (byte_index_q == 16'd2) length_n[7:0] = ub;
			if (byte_index_q == 16'd3) type_n = ub;
			if (byte_index_q >= 16'd3) sum_n = sum_q + ub;

			// The held byte goes out now, so the checksum byte never leaves.
			out_valid    = held_valid_q;
			held_valid_n = 1'b0;
			if (byte_index_q >= {9'd0, start} && type_n == rx_api_id_q) begin
				held_n       = ub;
				held_valid_n = 1'b1;
			end
			if (byte_index_q != MAX_FRAME_BYTES) byte_index_n = byte_index_q + 16'd1;
		end

		if (!delim_ok_n) begin
			verdict = VERDICT_BAD_DELIM;
		end else if (trailing || byte_index_n == MAX_FRAME_BYTES
				|| byte_index_n < HEADER_BYTES
				|| (byte_index_n - HEADER_BYTES) != length_n) begin
			verdict = VERDICT_BAD_LEN;
		end else if (sum_n != SUM_OK) begin
			verdict = VERDICT_BAD_SUM;
		end else if (type_n != rx_api_id_q) begin
			verdict = VERDICT_OTHER_API;
		end else begin
			verdict = VERDICT_OK;
		end
	end

	always_comb begin
		push.valid             = in_accept && (in_last || out_valid);
		push.res.payload_byte  = out_valid ? held_q : 8'd0;
		push.res.payload_valid = out_valid;
		push.res.frame_end     = in_last;
		push.res.verdict       = in_last ? verdict : VERDICT_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			esc_q        <= 1'b0;
			length_q     <= '0;
			sum_q        <= '0;
			type_q       <= '0;
			delim_ok_q   <= 1'b0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
		end else if (in_accept) begin
			if (in_last) begin
				byte_index_q <= '0;
				esc_q        <= 1'b0;
				length_q     <= '0;
				sum_q        <= '0;
				type_q       <= '0;
				delim_ok_q   <= 1'b0;
				held_q       <= '0;
				held_valid_q <= 1'b0;
			end else begin
				byte_index_q <= byte_index_n;
				esc_q        <= esc_n;
				length_q     <= length_n;
				sum_q        <= sum_n;
				type_q       <= type_n;
				delim_ok_q   <= delim_ok_n;
				held_q       <= held_n;
				held_valid_q <= held_valid_n;
			end
		end
	end

endmodule

// ===== design/adfc_back.sv =====
module adfc_back
	import adfc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_res
);

	res_t       entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign room      = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_res   = entry_q[rd_ptr_q];
	assign do_push   = push.valid && room;
	assign do_pop    = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push.res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/api_frame_deframer_checker.sv =====
// Receive checker for escaped radio-modem API frames with an 8-bit checksum.
// Raw bytes enter on s_axis one per transfer, s_axis_tlast on the frame's
// last raw byte. Unescaped payload bytes of frames whose API id matches
// rx_api_id leave on m_axis, held back one byte so the checksum stays in.
// The transfer taken with s_axis_tlast always yields one m_axis transfer with
// m_axis_tlast set and the verdict in m_axis_tuser; any verdict but ok means
// the payload already sent must be dropped downstream.
// A result is registered in a two-entry queue before it appears on m_axis.
// The block takes one byte per cycle while s_axis_tready is high; the front
// end updates all frame state on each accepted byte and writes results into the queue.
// When m_axis stalls, the queue absorbs up to two results, after which
// s_axis_tready falls until a result is taken.
// Reset clears the frame state and the queue and loads rx_api_id = 0x90 and
// payload_start = 15. The cfg port writes register 0 (rx_api_id) or
// register 1 (payload_start) when cfg_we is high; write only between frames.
module api_frame_deframer_checker
	import adfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // payload_byte
	output logic [3:0] m_axis_tuser,   // verdict[2:0], payload_valid
	output logic       m_axis_tlast
);

	push_t push;
	res_t  head;
	logic  room;
	logic  in_accept;

	assign in_accept     = s_axis_tvalid && room;
	assign s_axis_tready = room;

	adfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_accept (in_accept),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.push      (push)
	);

	adfc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (head)
	);

	assign m_axis_tdata = head.payload_byte;
	assign m_axis_tuser = {head.verdict, head.payload_valid};
	assign m_axis_tlast = head.frame_end;

`ifndef SYNTHESIS
	a_push_needs_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> s_axis_tvalid && s_axis_tready)
		else $error("result pushed without an input transfer");

	a_mid_frame_has_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[0] && m_axis_tuser[3:1] == VERDICT_OK)
		else $error("mid-frame result without payload or with a verdict");

	a_empty_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
		else $error("payload byte not zero while payload_valid is low");
`endif

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
	import adfc_pkg::*;

	typedef enum int {
		FAULT_NONE,
		FAULT_DELIM,
		FAULT_LENGTH,
		FAULT_SUM,
		FAULT_TRAILING_ESC,
		FAULT_TRUNCATE,
		FAULT_NOISE
	} frame_fault_e;

	// Mirrors the deframer's frame state and holds the results it must produce.
	class frame_verdict_scoreboard;
		logic [7:0]  api_id;
		logic [6:0]  pl_start;
		logic [15:0] ubyte_count;
		bit          esc_seen;
		logic [15:0] len_field;
		logic [7:0]  sum;
		logic [7:0]  ftype;
		bit          delim_good;
		logic [7:0]  held;
		bit          held_v;
		res_t        pending_results[$];
		int          errors;

		function void clear_frame();
			ubyte_count = '0;
			esc_seen = 0;
			len_field = '0;
			sum = '0;
			ftype = '0;
			delim_good = 0;
			held = '0;
			held_v = 0;
		endfunction

		function void init();
			api_id = RX_API_ID_RESET;
			pl_start = PAYLOAD_START_RESET;
			errors = 0;
			pending_results.delete();
			clear_frame();
		endfunction

		function void set_reg(logic idx, logic [7:0] value);
			if (idx == REG_RX_API_ID)
				api_id = value;
			else
				pl_start = value[6:0];
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void take_byte(logic [7:0] b, logic is_last);
			bit         have;
			bit         trailing;
			logic [7:0] ub;
			logic [7:0] out_b;
			bit         out_v;
			logic [6:0] start;
			res_t       r;

			have = 0;
			trailing = 0;
			ub = '0;
			out_b = '0;
			out_v = 0;
			start = (pl_start < MIN_PAYLOAD_START) ? MIN_PAYLOAD_START : pl_start;

			// The first byte is always taken literally, even when it is the escape code.
			if (ubyte_count == 0) begin
				delim_good = (b == DELIM);
				ub = b;
				have = 1;
			end else if (esc_seen) begin
				ub = b ^ ESC_XOR;
				esc_seen = 0;
				have = 1;
			end else if (b == ESC) begin
				if (is_last)
					trailing = 1;
				else
					esc_seen = 1;
			end else begin
				ub = b;
				have = 1;
			end

			if (have) begin
				if (ubyte_count == 1)
					len_field[15:8] = ub;
				else if (ubyte_count == 2)
					len_field[7:0] = ub;
				else if (ubyte_count == 3)
					ftype = ub;
				if (ubyte_count >= 3)
					sum = sum + ub;
				if (held_v) begin
					out_b = held;
					out_v = 1;
					held_v = 0;
				end
				if (ubyte_count >= {9'd0, start} && ftype == api_id) begin
					held = ub;
					held_v = 1;
				end
				if (ubyte_count != MAX_FRAME_BYTES)
					ubyte_count = ubyte_count + 16'd1;
			end

			if (is_last) begin
				r.payload_byte = out_v ? out_b : 8'h00;
				r.payload_valid = out_v;
				r.frame_end = 1'b1;
				if (!delim_good)
					r.verdict = VERDICT_BAD_DELIM;
				else if (trailing || ubyte_count == MAX_FRAME_BYTES ||
						ubyte_count < HEADER_BYTES ||
						ubyte_count - HEADER_BYTES != len_field)
					r.verdict = VERDICT_BAD_LEN;
				else if (sum != SUM_OK)
					r.verdict = VERDICT_BAD_SUM;
				else if (ftype != api_id)
					r.verdict = VERDICT_OTHER_API;
				else
					r.verdict = VERDICT_OK;
				pending_results.push_back(r);
				clear_frame();
			end else if (out_v) begin
				r.payload_byte = out_b;
				r.payload_valid = 1'b1;
				r.frame_end = 1'b0;
				r.verdict = VERDICT_OK;
				pending_results.push_back(r);
			end
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $time, msg);
			errors++;
		endtask

		task check_transfer(logic [7:0] data, logic [3:0] user, logic is_last);
			res_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected transfer data=%02h user=%h last=%b",
					data, user, is_last));
				return;
			end
			want = pending_results.pop_front();
			if (data !== want.payload_byte)
				report($sformatf("payload byte %02h, expected %02h", data, want.payload_byte));
			if (user[0] !== want.payload_valid)
				report($sformatf("payload valid %b, expected %b", user[0], want.payload_valid));
			if (is_last !== want.frame_end)
				report($sformatf("frame end %b, expected %b", is_last, want.frame_end));
			if (user[3:1] !== want.verdict)
				report($sformatf("verdict %0d, expected %0d", user[3:1], want.verdict));
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_data;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic [3:0] m_axis_tuser;
	logic       m_axis_tlast;

	frame_verdict_scoreboard sb;
	logic [7:0] frame_q[$];
	int         idle_pct;
	int         stall_pct;
	bit         random_drains;
	int         bytes_sent;

	api_frame_deframer_checker i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

	// Output side: check every transfer, then pick the next ready level.
	initial begin
		m_axis_tready = 1'b1;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				sb.check_transfer(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);
		end
	end

	// Waits until every expected result has been taken, with the input side idle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic quiesce();
		drain();
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.set_reg(idx, value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_byte(logic [7:0] b, logic is_last);
		if (random_drains && $urandom_range(63, 0) == 0)
			drain();
		while ($urandom_range(99, 0) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= is_last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.take_byte(b, is_last);
		bytes_sent++;
	endtask

	// A negative pause_at sends the frame without a pause for the output to empty.
	task automatic send_frame_q(int pause_at);
		for (int i = 0; i < frame_q.size(); i++) begin
			if (i == pause_at)
				drain();
			send_byte(frame_q[i], i == frame_q.size() - 1);
		end
	endtask

	function automatic logic [7:0] pick_data_byte();
		case ($urandom_range(5, 0))
			0: return 8'h00;
			1: return 8'hFF;
			2: return DELIM;
			3: return ESC;
			default: return 8'($urandom);
		endcase
	endfunction

	// Builds the raw bytes of one frame, escaped, into frame_q.
	task automatic build_frame(logic [7:0] ftype, int dlen, frame_fault_e fault);
		logic [7:0]  u[$];
		logic [7:0]  s;
		logic [7:0]  b;
		logic [15:0] ln;
		int          cut;

		frame_q.delete();
		if (fault == FAULT_NOISE) begin
			cut = $urandom_range(24, 1);
			for (int i = 0; i < cut; i++)
				frame_q.push_back(pick_data_byte());
			return;
		end
		ln = 16'(dlen + 1);
		if (fault == FAULT_LENGTH)
			ln = ln + 16'($urandom_range(16'hFFFF, 1));
		b = 8'($urandom);
		if (b == DELIM)
			b = ESC;
		u.push_back(fault == FAULT_DELIM ? b : DELIM);
		u.push_back(ln[15:8]);
		u.push_back(ln[7:0]);
		u.push_back(ftype);
		s = ftype;
		for (int i = 0; i < dlen; i++) begin
			b = pick_data_byte();
			s = s + b;
			u.push_back(b);
		end
		s = SUM_OK - s;
		if (fault == FAULT_SUM)
			s = s ^ 8'($urandom_range(255, 1));
		u.push_back(s);
		if (fault == FAULT_TRUNCATE) begin
			cut = $urandom_range(u.size() - 1, 1);
			while (u.size() > cut)
				void'(u.pop_back());
		end
		frame_q.push_back(u[0]);
		for (int i = 1; i < u.size(); i++) begin
			if (u[i] == DELIM || u[i] == ESC || u[i] == 8'h11 || u[i] == 8'h13 ||
					$urandom_range(11, 0) == 0) begin
				frame_q.push_back(ESC);
				frame_q.push_back(u[i] ^ ESC_XOR);
			end else begin
				frame_q.push_back(u[i]);
			end
		end
		if (fault == FAULT_TRAILING_ESC)
			frame_q.push_back(ESC);
	endtask

	task automatic run_phase(logic [7:0] api, logic [7:0] pstart, int idle, int stall,
			int budget);
		int           stop_at;
		int           dlen;
		logic [7:0]   ftype;
		frame_fault_e fault;

		quiesce();
		write_reg(REG_RX_API_ID, api);
		write_reg(REG_PAYLOAD_START, pstart);
		idle_pct = idle;
		stall_pct = stall;
		random_drains = 1;
		stop_at = bytes_sent + budget;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(99, 0) < 70)
				fault = FAULT_NONE;
			else
				fault = frame_fault_e'($urandom_range(FAULT_NOISE, FAULT_DELIM));
			ftype = ($urandom_range(3, 0) != 0) ? api : 8'($urandom);
			if ($urandom_range(9, 0) == 0)
				dlen = $urandom_range(140, 0);
			else
				dlen = $urandom_range(30, 0);
			build_frame(ftype, dlen, fault);
			send_frame_q(-1);
		end
	endtask

	initial begin
		sb = new();
		sb.init();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_RX_API_ID;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		random_drains = 0;
		bytes_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Frames at the reset settings: lone delimiter, escape code in the
		// delimiter position, then a minimal good frame.
		frame_q = {DELIM};
		send_frame_q(-1);
		frame_q = {ESC};
		send_frame_q(-1);
		frame_q = {DELIM, 8'h00, 8'h01, RX_API_ID_RESET, 8'h6F};
		send_frame_q(-1);

		quiesce();
		write_reg(REG_PAYLOAD_START, 8'd4);
		// Escaped delimiter and extreme payload values; the input side waits for
		// the output to empty in the middle of the payload.
		frame_q = {DELIM, 8'h00, 8'h04, RX_API_ID_RESET, ESC, 8'h5E, 8'hFF, 8'h00, 8'hF2};
		send_frame_q(7);
		// Escape on the last byte, bad checksum, and a foreign API id.
		frame_q = {DELIM, 8'h00, 8'h00, ESC};
		send_frame_q(-1);
		frame_q = {DELIM, 8'h00, 8'h01, RX_API_ID_RESET, 8'h00};
		send_frame_q(-1);
		frame_q = {DELIM, 8'h00, 8'h01, 8'h12, 8'hED};
		send_frame_q(-1);

		bytes_sent = 0;
		run_phase(8'h00, 8'd0, 0, 0, 290);
		run_phase(8'hFF, 8'd127, 81, 0, 290);
		run_phase(RX_API_ID_RESET, 8'd64, 0, 81, 290);
		run_phase(8'($urandom), 8'($urandom_range(20, 4)), 29, 29, 290);
		run_phase(RX_API_ID_RESET, PAYLOAD_START_RESET, 0, 0, 290);

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
